>>> sv/ccc_pkg.sv
package ccc_pkg;

  localparam int SQ_STEPS = 31;
  localparam int DV_STEPS = 17;

  typedef struct packed {
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic [29:0]        a_radius;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic [29:0]        b_radius;
  } in_beat_t;

  typedef struct packed {
    logic               hit;
    logic [30:0]        depth;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [31:0] contact_x;
    logic signed [31:0] contact_y;
  } out_beat_t;

  // rsum holds the radius sum in the root chain and the depth in the divide chain
  typedef struct packed {
    logic               hit;
    logic               zero;
    logic               sx;
    logic               sy;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic [29:0]        ar;
    logic [30:0]        rsum;
    logic [30:0]        adx;
    logic [30:0]        ady;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [61:0] rad;
    logic [32:0] rem;
    logic [30:0] root;
  } sq_t;

  typedef struct packed {
    side_t       side;
    logic [31:0] d;
    logic [31:0] rem_x;
    logic [31:0] rem_y;
    logic [16:0] nb_x;
    logic [16:0] nb_y;
    logic [16:0] q_x;
    logic [16:0] q_y;
  } dv_t;

  // one restoring divide step: {quotient bit, new remainder}
  function automatic logic [32:0] div_step(input logic [31:0] rem, input logic nb,
                                           input logic [31:0] d);
    logic [32:0] r;
    logic [32:0] dd;
    r  = {rem, nb};
    dd = {1'b0, d};
    if (r >= dd) begin
      div_step = {1'b1, 32'(r - dd)};
    end else begin
      div_step = {1'b0, r[31:0]};
    end
  endfunction

endpackage

>>> sv/ccc_sqrt_cell.sv
module ccc_sqrt_cell import ccc_pkg::*; (
  input  logic clk,
  input  logic en,
  input  sq_t  a,
  output sq_t  y_r
);

  sq_t         y_nxt;
  logic [34:0] r4;
  logic [34:0] trial;

  always_comb begin
    r4          = {a.rem, a.rad[61:60]};
    trial       = {2'b00, a.root, 2'b01};
    y_nxt       = a;
    y_nxt.rad   = {a.rad[59:0], 2'b00};
    if (r4 >= trial) begin
      y_nxt.rem  = 33'(r4 - trial);
      y_nxt.root = {a.root[29:0], 1'b1};
    end else begin
      y_nxt.rem  = r4[32:0];
      y_nxt.root = {a.root[29:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_r <= y_nxt;
    end
  end

endmodule

>>> sv/ccc_div_cell.sv
module ccc_div_cell import ccc_pkg::*; (
  input  logic clk,
  input  logic en,
  input  dv_t  a,
  output dv_t  y_r
);

  dv_t         y_nxt;
  logic [32:0] sx;
  logic [32:0] sy;

  always_comb begin
    sx          = div_step(a.rem_x, a.nb_x[16], a.d);
    sy          = div_step(a.rem_y, a.nb_y[16], a.d);
    y_nxt       = a;
    y_nxt.rem_x = sx[31:0];
    y_nxt.rem_y = sy[31:0];
    y_nxt.q_x   = {a.q_x[15:0], sx[32]};
    y_nxt.q_y   = {a.q_y[15:0], sy[32]};
    y_nxt.nb_x  = {a.nb_x[15:0], 1'b0};
    y_nxt.nb_y  = {a.nb_y[15:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_r <= y_nxt;
    end
  end

endmodule

>>> sv/circle_circle_contact_top.sv
// channel | ports                          | beat
// in      | in_valid, in_stall, in_beat    | in_beat_t (two circles)
// out     | out_valid, out_stall, out_beat | out_beat_t (contact)
//
// One beat per cycle unless stalled; stages A, B, 31 root cells, 17 divide cells, E, output.
// The square root runs one result bit per cell, the normal divide one quotient bit per cell.
// rst_n is synchronous; it clears the valid bits only.
// A stalled output freezes the whole pipe, so in_stall follows out_stall while out_valid is up.
module circle_circle_contact_top import ccc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_beat
);

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage A: input register
  in_beat_t a_r;
  logic     va_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= in_beat;
    end
  end

  // stage B: differences and squares
  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic [32:0]        adx;
  logic [32:0]        ady;
  logic [30:0]        rsum;
  assign dx   = 33'(a_r.b_x) - 33'(a_r.a_x);
  assign dy   = 33'(a_r.b_y) - 33'(a_r.a_y);
  assign adx  = dx[32] ? 33'(-dx) : 33'(dx);
  assign ady  = dy[32] ? 33'(-dy) : 33'(dy);
  assign rsum = 31'(a_r.a_radius) + 31'(a_r.b_radius);

  side_t       b_side_r;
  logic        b_far_r;
  logic [61:0] sqx_r;
  logic [61:0] sqy_r;
  logic [61:0] rs2_r;
  logic        vb_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b_far_r       <= adx[32] || adx[31] || ady[32] || ady[31];
      sqx_r         <= adx[30:0] * adx[30:0];
      sqy_r         <= ady[30:0] * ady[30:0];
      rs2_r         <= rsum * rsum;
      b_side_r.hit  <= 1'b0;
      b_side_r.zero <= 1'b0;
      b_side_r.sx   <= dx[32];
      b_side_r.sy   <= dy[32];
      b_side_r.ax   <= a_r.a_x;
      b_side_r.ay   <= a_r.a_y;
      b_side_r.ar   <= a_r.a_radius;
      b_side_r.rsum <= rsum;
      b_side_r.adx  <= adx[30:0];
      b_side_r.ady  <= ady[30:0];
    end
  end

  // stage C: overlap test feeds the root chain
  logic [62:0] d2;
  sq_t         sq0;
  assign d2 = 63'(sqx_r) + 63'(sqy_r);
  always_comb begin
    sq0           = '0;
    sq0.side      = b_side_r;
    sq0.side.hit  = !b_far_r && (d2 < 63'(rs2_r));
    sq0.side.zero = (d2 == '0);
    sq0.rad       = d2[61:0];
  end

  sq_t  sq_q [SQ_STEPS];
  logic vsq_r [SQ_STEPS];
  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
    if (i == 0) begin : g_first
      ccc_sqrt_cell u_cell (.clk(clk), .en(en), .a(sq0), .y_r(sq_q[i]));
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vsq_r[i] <= 1'b0;
        end else if (en) begin
          vsq_r[i] <= vb_r;
        end
      end
    end else begin : g_next
      ccc_sqrt_cell u_cell (.clk(clk), .en(en), .a(sq_q[i-1]), .y_r(sq_q[i]));
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vsq_r[i] <= 1'b0;
        end else if (en) begin
          vsq_r[i] <= vsq_r[i-1];
        end
      end
    end
  end

  // rounding, depth and divide setup
  sq_t         sq_l;
  logic [31:0] dist_rnd;
  logic [46:0] num_x;
  logic [46:0] num_y;
  dv_t         dv0;
  assign sq_l     = sq_q[SQ_STEPS-1];
  assign dist_rnd = 32'(sq_l.root) + 32'(sq_l.rem > 33'(sq_l.root));
  assign num_x    = {1'b0, sq_l.side.adx, 15'd0} + 47'(dist_rnd[31:1]);
  assign num_y    = {1'b0, sq_l.side.ady, 15'd0} + 47'(dist_rnd[31:1]);
  always_comb begin
    dv0           = '0;
    dv0.side      = sq_l.side;
    dv0.side.rsum = 31'(32'(sq_l.side.rsum) - dist_rnd);
    dv0.d         = dist_rnd;
    dv0.rem_x     = 32'(num_x[46:17]);
    dv0.rem_y     = 32'(num_y[46:17]);
    dv0.nb_x      = num_x[16:0];
    dv0.nb_y      = num_y[16:0];
  end

  dv_t  dv_q [DV_STEPS];
  logic vdv_r [DV_STEPS];
  for (genvar i = 0; i < DV_STEPS; i++) begin : g_dv
    if (i == 0) begin : g_first
      ccc_div_cell u_cell (.clk(clk), .en(en), .a(dv0), .y_r(dv_q[i]));
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vdv_r[i] <= 1'b0;
        end else if (en) begin
          vdv_r[i] <= vsq_r[SQ_STEPS-1];
        end
      end
    end else begin : g_next
      ccc_div_cell u_cell (.clk(clk), .en(en), .a(dv_q[i-1]), .y_r(dv_q[i]));
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vdv_r[i] <= 1'b0;
        end else if (en) begin
          vdv_r[i] <= vdv_r[i-1];
        end
      end
    end
  end

  // stage E: clamp normals, scale by radius
  dv_t                dv_l;
  logic [15:0]        mx;
  logic [15:0]        my;
  logic signed [15:0] nx;
  logic signed [15:0] ny;
  assign dv_l = dv_q[DV_STEPS-1];
  always_comb begin
    if (dv_l.side.sx) begin
      mx = (dv_l.q_x > 17'd32768) ? 16'd32768 : dv_l.q_x[15:0];
      nx = 16'(-mx);
    end else begin
      mx = (dv_l.q_x > 17'd32767) ? 16'd32767 : dv_l.q_x[15:0];
      nx = 16'(mx);
    end
    if (dv_l.side.sy) begin
      my = (dv_l.q_y > 17'd32768) ? 16'd32768 : dv_l.q_y[15:0];
      ny = 16'(-my);
    end else begin
      my = (dv_l.q_y > 17'd32767) ? 16'd32767 : dv_l.q_y[15:0];
      ny = 16'(my);
    end
  end

  side_t              e_side_r;
  logic signed [15:0] e_nx_r;
  logic signed [15:0] e_ny_r;
  logic [45:0]        e_px_r;
  logic [45:0]        e_py_r;
  logic               ve_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (en) begin
      ve_r <= vdv_r[DV_STEPS-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      e_side_r <= dv_l.side;
      e_nx_r   <= nx;
      e_ny_r   <= ny;
      e_px_r   <= mx * dv_l.side.ar;
      e_py_r   <= my * dv_l.side.ar;
    end
  end

  // stage F: round offset, add to A center, saturate
  logic [31:0]        offx;
  logic [31:0]        offy;
  logic signed [33:0] sumx;
  logic signed [33:0] sumy;
  logic signed [31:0] cx;
  logic signed [31:0] cy;
  out_beat_t          res;
  logic [46:0]        rx;
  logic [46:0]        ry;
  assign rx   = 47'(e_px_r) + 47'd16384;
  assign ry   = 47'(e_py_r) + 47'd16384;
  assign offx = rx[46:15];
  assign offy = ry[46:15];
  assign sumx = e_nx_r[15] ? 34'(e_side_r.ax) - 34'(offx) : 34'(e_side_r.ax) + 34'(offx);
  assign sumy = e_ny_r[15] ? 34'(e_side_r.ay) - 34'(offy) : 34'(e_side_r.ay) + 34'(offy);
  always_comb begin
    if (sumx > 34'sd2147483647) begin
      cx = 32'sh7fffffff;
    end else if (sumx < -34'sd2147483648) begin
      cx = 32'sh80000000;
    end else begin
      cx = sumx[31:0];
    end
    if (sumy > 34'sd2147483647) begin
      cy = 32'sh7fffffff;
    end else if (sumy < -34'sd2147483648) begin
      cy = 32'sh80000000;
    end else begin
      cy = sumy[31:0];
    end
    res = '0;
    if (e_side_r.hit) begin
      res.hit = 1'b1;
      if (e_side_r.zero) begin
        res.depth     = 31'(e_side_r.ar);
        res.normal_x  = 16'sd32767;
        res.normal_y  = '0;
        res.contact_x = e_side_r.ax;
        res.contact_y = e_side_r.ay;
      end else begin
        res.depth     = e_side_r.rsum;
        res.normal_x  = e_nx_r;
        res.normal_y  = e_ny_r;
        res.contact_x = cx;
        res.contact_y = cy;
      end
    end
  end

  logic      out_valid_r;
  out_beat_t out_beat_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ve_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_beat_r <= res;
    end
  end
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  a_nohit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_beat.hit) |-> (out_beat.depth == '0 && out_beat.normal_x == '0 &&
      out_beat.normal_y == '0 && out_beat.contact_x == '0 && out_beat.contact_y == '0))
    else $error("miss beat carries nonzero fields");

  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall not tied to output backpressure");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule
